// ===== src/video_register_port_with_autoincrement_unit_defines.svh =====
// Assertion macros used by the video register port controller.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef VIDEO_REGISTER_PORT_WITH_AUTOINCREMENT_UNIT_DEFINES_SVH
`define VIDEO_REGISTER_PORT_WITH_AUTOINCREMENT_UNIT_DEFINES_SVH

// condition holds at every edge out of reset
`define VRP_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// trigger at one edge implies condition at the next
`define VRP_ASSERT_NEXT(lbl, trig, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (expr)) \
		else $error(msg);

`endif

// ===== src/vrp_pkg.sv =====
// Shared constants, codes and the controller command struct of the video register port.
// No dependencies.
package vrp_pkg;

	localparam int CMD_W     = 2;
	localparam int ADDR_W    = 8;
	localparam int DATA_W    = 8;
	localparam int CFG_W     = 17;
	localparam int CFG_IDX_W = 2;
	localparam int TICK_W    = 17;

	localparam int REG_COUNT  = 256;
	localparam int SPR_DEPTH  = 2048;
	localparam int SPR_AW     = $clog2(SPR_DEPTH);
	localparam int VRAM_DEPTH = 8192;
	localparam int VRAM_AW    = $clog2(VRAM_DEPTH);

	localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

	localparam logic [ADDR_W-1:0] PORT_CTRL    = 8'h00;
	localparam logic [ADDR_W-1:0] PORT_STATUS  = 8'h01;
	localparam logic [ADDR_W-1:0] PORT_SP_HI   = 8'h02;
	localparam logic [ADDR_W-1:0] PORT_SP_LO   = 8'h03;
	localparam logic [ADDR_W-1:0] PORT_SP_DATA = 8'h04;
	localparam logic [ADDR_W-1:0] PORT_VR_LO   = 8'h05;
	localparam logic [ADDR_W-1:0] PORT_VR_HI   = 8'h06;
	localparam logic [ADDR_W-1:0] PORT_VR_DATA = 8'h07;

	localparam logic [CFG_IDX_W-1:0] CFG_VBLANK_START  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VBLANK_LENGTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH  = 2'd2;

	localparam logic [CFG_W-1:0] VBLANK_START_RST  = 17'd0;
	localparam logic [CFG_W-1:0] VBLANK_LENGTH_RST = 17'd22036;
	localparam logic [CFG_W-1:0] FRAME_LENGTH_RST  = 17'd106392;

	typedef struct packed {
		logic               clear;
		logic [VRAM_AW-1:0] clear_addr;
		logic               capture;
		logic               exec;
	} vrp_cmd_t;

endpackage

// ===== src/video_register_port_with_autoincrement_unit.sv =====
// Top level of the video register port: controller plus datapath.
// Depends on vrp_pkg, vrp_ctrl and vrp_datapath.
//
// channel   | ports                                         | handshake
// ----------+-----------------------------------------------+-------------------------------
// request   | cmd, address, write_data                      | start high while busy low
// result    | read_data, vblank, render_start, nmi_enable   | done strobe, one cycle
// config    | cfg_index, cfg_data                           | cfg_write, taken at once
//
// A request runs through an execute state with the RAM access and then a state with done high;
// a new request can be taken while done is high. The RAM read ports are registered, so read
// data is ready in the done state. After reset the sprite and video RAMs are cleared, one
// address per cycle, and busy stays high until the last video RAM address is cleared. Results
// (read_data, render_start) stay until the next request; done marks each for a single cycle.
module video_register_port_with_autoincrement_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [vrp_pkg::CMD_W-1:0]     cmd,
	input  logic [vrp_pkg::ADDR_W-1:0]    address,
	input  logic [vrp_pkg::DATA_W-1:0]    write_data,
	output logic                          done,
	output logic [vrp_pkg::DATA_W-1:0]    read_data,
	output logic                          vblank,
	output logic                          render_start,
	output logic                          nmi_enable,
	input  logic                          cfg_write,
	input  logic [vrp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [vrp_pkg::CFG_W-1:0]     cfg_data
);
	import vrp_pkg::*;

	vrp_cmd_t ctl;

	vrp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.ctl    (ctl)
	);

	vrp_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.cmd          (cmd),
		.address      (address),
		.write_data   (write_data),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.read_data    (read_data),
		.vblank       (vblank),
		.render_start (render_start),
		.nmi_enable   (nmi_enable)
	);

endmodule

// ===== src/vrp_datapath.sv =====
// Datapath of the video register port: register file, sprite and video RAMs,
// address auto-increment, frame tick counter and result registers. Uses vrp_pkg.
module vrp_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  vrp_pkg::vrp_cmd_t            ctl,
	input  logic [vrp_pkg::CMD_W-1:0]    cmd,
	input  logic [vrp_pkg::ADDR_W-1:0]   address,
	input  logic [vrp_pkg::DATA_W-1:0]   write_data,
	input  logic                         cfg_write,
	input  logic [vrp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [vrp_pkg::CFG_W-1:0]    cfg_data,
	output logic [vrp_pkg::DATA_W-1:0]   read_data,
	output logic                         vblank,
	output logic                         render_start,
	output logic                         nmi_enable
);
	import vrp_pkg::*;

	typedef enum logic [2:0] {
		RD_ZERO,
		RD_SPR,
		RD_VID,
		RD_RF,
		RD_REG
	} rd_src_t;

	logic [CMD_W-1:0]  cmd_q;
	logic [ADDR_W-1:0] addr_q;
	logic [DATA_W-1:0] wdata_q;

	logic [DATA_W-1:0] reg0_q, reg2_q, reg3_q, reg5_q, reg6_q;
	logic [TICK_W-1:0] tick_q;
	logic [CFG_W-1:0]  vstart_q, vlen_q, flen_q;

	logic [DATA_W-1:0] rf_mem [REG_COUNT];
	logic [REG_COUNT-1:0] rf_valid_q;
	logic [DATA_W-1:0] rf_rd_q;
	logic              rf_vld_rd_q;

	logic [DATA_W-1:0] sp_mem [SPR_DEPTH];
	logic [DATA_W-1:0] sp_rd_q;
	logic [DATA_W-1:0] vr_mem [VRAM_DEPTH];
	logic [DATA_W-1:0] vr_rd_q;

	rd_src_t           src_q;
	logic [DATA_W-1:0] reg_rd_q;
	logic              rs_q;

	logic [SPR_AW-1:0]  sp_addr, sp_next, sp_wa;
	logic [SPR_AW:0]    sp_inc;
	logic [VRAM_AW-1:0] vr_addr, vr_next, vr_wa;
	logic               sp_we, vr_we, rf_we;
	logic               is_rd, is_wr, is_tick;
	logic [DATA_W-1:0]  mem_wd;
	logic [TICK_W:0]    tick_inc;
	logic               tick_wrap;
	logic               vblank_now;
	rd_src_t            src_d;
	logic [DATA_W-1:0]  reg_rd_d;

	assign sp_addr = {reg2_q[SPR_AW-DATA_W-1:0], reg3_q};
	assign vr_addr = {reg6_q[VRAM_AW-DATA_W-1:0], reg5_q};

	assign is_rd   = ctl.exec && (cmd_q == CMD_READ);
	assign is_wr   = ctl.exec && (cmd_q == CMD_WRITE);
	assign is_tick = ctl.exec && (cmd_q == CMD_TICK);

	assign vblank_now = (tick_q >= vstart_q) && (tick_q < vlen_q);

	// skip offsets 6 and 7 of each 8-byte sprite entry
	always_comb begin
		sp_inc = {1'b0, sp_addr} + {{SPR_AW{1'b0}}, 1'b1};
		if (sp_inc[2:1] == 2'b11) begin
			sp_inc = {sp_inc[SPR_AW:3] + {{(SPR_AW-3){1'b0}}, 1'b1}, 3'b000};
		end
		sp_next = sp_inc[SPR_AW-1:0];
	end

	assign vr_next = vr_addr + {{(VRAM_AW-1){1'b0}}, 1'b1};

	assign sp_we = ctl.clear || (is_wr && addr_q == PORT_SP_DATA);
	assign vr_we = ctl.clear || (is_wr && addr_q == PORT_VR_DATA);
	assign rf_we = is_wr && addr_q != PORT_SP_DATA && addr_q != PORT_VR_DATA;
	assign sp_wa = ctl.clear ? ctl.clear_addr[SPR_AW-1:0] : sp_addr;
	assign vr_wa = ctl.clear ? ctl.clear_addr : vr_addr;
	assign mem_wd = ctl.clear ? '0 : wdata_q;

	assign tick_inc  = {1'b0, tick_q} + {{TICK_W{1'b0}}, 1'b1};
	assign tick_wrap = tick_inc >= {1'b0, flen_q};

	always_comb begin
		src_d    = RD_ZERO;
		reg_rd_d = '0;
		if (is_rd) begin
			case (addr_q)
				PORT_SP_DATA: src_d = RD_SPR;
				PORT_VR_DATA: src_d = RD_VID;
				PORT_STATUS: begin
					src_d    = RD_REG;
					reg_rd_d = {vblank_now, {(DATA_W-1){1'b0}}};
				end
				PORT_CTRL: begin
					src_d    = RD_REG;
					reg_rd_d = reg0_q;
				end
				PORT_SP_HI: begin
					src_d    = RD_REG;
					reg_rd_d = reg2_q;
				end
				PORT_SP_LO: begin
					src_d    = RD_REG;
					reg_rd_d = reg3_q;
				end
				PORT_VR_LO: begin
					src_d    = RD_REG;
					reg_rd_d = reg5_q;
				end
				PORT_VR_HI: begin
					src_d    = RD_REG;
					reg_rd_d = reg6_q;
				end
				default: src_d = RD_RF;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q   <= cmd;
			addr_q  <= address;
			wdata_q <= write_data;
		end
	end

	always_ff @(posedge clk) begin
		if (sp_we) begin
			sp_mem[sp_wa] <= mem_wd;
		end
		if (is_rd) begin
			sp_rd_q <= sp_mem[sp_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (vr_we) begin
			vr_mem[vr_wa] <= mem_wd;
		end
		if (is_rd) begin
			vr_rd_q <= vr_mem[vr_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (rf_we) begin
			rf_mem[addr_q] <= wdata_q;
		end
		if (is_rd) begin
			rf_rd_q <= rf_mem[addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_valid_q  <= '0;
			rf_vld_rd_q <= 1'b0;
			reg0_q      <= '0;
			reg2_q      <= '0;
			reg3_q      <= '0;
			reg5_q      <= '0;
			reg6_q      <= '0;
			tick_q      <= '0;
			src_q       <= RD_ZERO;
			reg_rd_q    <= '0;
			rs_q        <= 1'b0;
		end else begin
			if (ctl.exec) begin
				src_q    <= src_d;
				reg_rd_q <= reg_rd_d;
				rs_q     <= 1'b0;
			end
			if (is_rd) begin
				rf_vld_rd_q <= rf_valid_q[addr_q];
			end
			if (rf_we) begin
				rf_valid_q[addr_q] <= 1'b1;
				case (addr_q)
					PORT_CTRL:  reg0_q <= wdata_q;
					PORT_SP_HI: reg2_q <= wdata_q;
					PORT_SP_LO: reg3_q <= wdata_q;
					PORT_VR_LO: reg5_q <= wdata_q;
					PORT_VR_HI: reg6_q <= wdata_q;
					default: ;
				endcase
			end
			if (is_wr && addr_q == PORT_SP_DATA) begin
				reg2_q <= {{(2*DATA_W-SPR_AW){1'b0}}, sp_next[SPR_AW-1:DATA_W]};
				reg3_q <= sp_next[DATA_W-1:0];
			end
			if (is_wr && addr_q == PORT_VR_DATA) begin
				reg6_q <= {{(2*DATA_W-VRAM_AW){1'b0}}, vr_next[VRAM_AW-1:DATA_W]};
				reg5_q <= vr_next[DATA_W-1:0];
			end
			if (is_tick) begin
				tick_q <= tick_wrap ? '0 : tick_inc[TICK_W-1:0];
				rs_q   <= !tick_wrap && (tick_inc == {1'b0, vlen_q});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vstart_q <= VBLANK_START_RST;
			vlen_q   <= VBLANK_LENGTH_RST;
			flen_q   <= FRAME_LENGTH_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_VBLANK_START:  vstart_q <= cfg_data;
				CFG_VBLANK_LENGTH: vlen_q   <= cfg_data;
				CFG_FRAME_LENGTH:  flen_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (src_q)
			RD_SPR:  read_data = sp_rd_q;
			RD_VID:  read_data = vr_rd_q;
			RD_RF:   read_data = rf_vld_rd_q ? rf_rd_q : '0;
			RD_REG:  read_data = reg_rd_q;
			default: read_data = '0;
		endcase
	end

	assign vblank       = vblank_now;
	assign render_start = rs_q;
	assign nmi_enable   = reg0_q[0];

endmodule

// ===== src/vrp_ctrl.sv =====
// Controller of the video register port: RAM clear sweep after reset, request
// sequencing, busy and done. Uses vrp_pkg and the assertion macro header.
`include "video_register_port_with_autoincrement_unit_defines.svh"

module vrp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              done,
	output vrp_pkg::vrp_cmd_t ctl
);
	import vrp_pkg::*;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_DONE
	} state_t;

	state_t             state_q;
	logic [VRAM_AW-1:0] clr_q;
	logic               busy_q;
	logic               done_q;
	logic               accept;

	assign accept = start && !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			busy_q  <= 1'b1;
			done_q  <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + {{(VRAM_AW-1){1'b0}}, 1'b1};
					if (&clr_q) begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
					end
				end
				S_IDLE, S_DONE: begin
					done_q <= 1'b0;
					if (accept) begin
						state_q <= S_EXEC;
						busy_q  <= 1'b1;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_EXEC: begin
					state_q <= S_DONE;
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b0;
				end
			endcase
		end
	end

	assign ctl.clear      = (state_q == S_CLEAR);
	assign ctl.clear_addr = clr_q;
	assign ctl.capture    = accept;
	assign ctl.exec       = (state_q == S_EXEC);

	assign busy = busy_q;
	assign done = done_q;

	`VRP_ASSERT(a_busy_done_excl, !(busy_q && done_q), "busy and done high together")
	`VRP_ASSERT_NEXT(a_exec_then_done, state_q == S_EXEC, done_q && !busy_q,
		"request not completed one cycle after execution")
	`VRP_ASSERT_NEXT(a_accept_busy, accept, busy_q && !done_q, "accepted request did not raise busy")
	`VRP_ASSERT(a_clear_busy, (state_q != S_CLEAR) || busy_q, "request port open during clear")

endmodule
